/* rtl/core/pfs_pkg.sv */
// shared constants and types for the phi function series evaluator
package pfs_pkg;

    localparam int MAX_ORDER    = 15;
    localparam int SERIES_TERMS = 8;

    // field widths
    localparam int ORD_W = 4;
    localparam int Z_W   = 32;
    localparam int OUT_W = 32;

    // divisor range: 1 .. MAX_ORDER + SERIES_TERMS
    localparam int K_W = $clog2(MAX_ORDER + SERIES_TERMS + 1);

    // fixed point formats
    localparam int Z_FRAC   = 30;
    localparam int ACC_FRAC = 29;
    localparam int OUT_FRAC = 27;

    // accumulator magnitude is clipped to 2^MAG_W - 1
    localparam int MAG_W  = 32;
    localparam int ACC_W  = MAG_W + 2;
    localparam int PROD_W = Z_W + MAG_W;

    // digit-serial divider: DIG_W quotient bits per cycle
    localparam int DIG_W      = 8;
    localparam int HI_W       = PROD_W - Z_FRAC;
    localparam int DIV_SRC_W  = (HI_W > MAG_W) ? HI_W : MAG_W;
    localparam int DIV_DIGITS = (DIV_SRC_W + DIG_W - 1) / DIG_W;
    localparam int DIV_W      = DIV_DIGITS * DIG_W;
    localparam int DCNT_W     = $clog2(DIV_DIGITS + 1);

    // width of the Horner update sum before clipping
    localparam int UPD_W = DIV_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(64'sd1 <<< ACC_FRAC);
    localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'((64'sd1 <<< MAG_W) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MAX   =
        ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN   = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MULW,
        S_HDIV,
        S_FDIV,
        S_FWAIT,
        S_FIN
    } t_state;

endpackage

/* rtl/core/phi_function_series.sv */
// top level: phi_n(z) by a truncated Horner series on a shared multiplier and divider
//
// Computes phi_n(z) for order n (saturated to 15) and z in signed Q1.30, giving
// a signed Q4.27 result and a saturation flag. One transaction is in flight at
// a time: o_in_stall stays high from acceptance until the result is loaded into
// the output register. The work is paced by a small sequencer around one
// 32x32 multiplier and one divider that retires eight quotient bits per cycle
// (five quotient digits per division). Each of the eight series terms is a
// multiply, a product hand-off and a division. After setup and the series,
// the sum is divided by n! one factor at a time, n-1 divisions for n >= 2 and
// none for n of 0 or 1, before the output step. The next transaction can be
// accepted once the result is loaded. The output register lets a new
// transaction be accepted while the previous result still waits; a finished
// result waits in the sequencer until the output is free.
module phi_function_series (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pfs_pkg::ORD_W-1:0]         i_order,
    input  logic signed [pfs_pkg::Z_W-1:0]    i_z,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [pfs_pkg::OUT_W-1:0]  o_phi_value,
    output logic                              o_saturated
);

    // sequencer state
    pfs_pkg::t_state r_state;
    pfs_pkg::t_state n_state;

    // working registers
    logic signed [pfs_pkg::Z_W-1:0]    r_z;
    logic signed [pfs_pkg::Z_W-1:0]    n_z;
    logic [pfs_pkg::K_W-1:0]           r_ord;
    logic [pfs_pkg::K_W-1:0]           n_ord;
    logic [pfs_pkg::K_W-1:0]           r_k;
    logic [pfs_pkg::K_W-1:0]           n_k;
    logic signed [pfs_pkg::ACC_W-1:0]  r_acc;
    logic signed [pfs_pkg::ACC_W-1:0]  n_acc;
    logic                              r_neg;
    logic                              n_neg;
    logic                              r_sat;
    logic                              n_sat;
    logic                              r_lo_ge;
    logic                              n_lo_ge;

    // output register
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic signed [pfs_pkg::OUT_W-1:0]  r_phi;
    logic signed [pfs_pkg::OUT_W-1:0]  n_phi;
    logic                              r_sat_out;
    logic                              n_sat_out;

    // shared units
    logic                              mul_start;
    logic                              mul_done;
    logic [pfs_pkg::Z_W-1:0]           z_mag;
    logic [pfs_pkg::MAG_W-1:0]         acc_mag;
    logic [pfs_pkg::ACC_W-1:0]         acc_abs;
    logic [pfs_pkg::PROD_W-1:0]        prod;

    logic                              div_start;
    logic                              div_done;
    logic [pfs_pkg::DIV_W-1:0]         div_dividend;
    logic [pfs_pkg::DIV_W-1:0]         div_quot;
    logic [pfs_pkg::K_W-1:0]           div_rem;

    logic                              in_accept;
    logic                              out_free;
    logic                              last_term;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_term = (r_k == pfs_pkg::K_W'(r_ord + 1'b1));

    // magnitudes feeding the unsigned multiplier; |-2^31| still fits in Z_W bits
    assign z_mag   = r_z[pfs_pkg::Z_W-1] ? pfs_pkg::Z_W'(-r_z) : pfs_pkg::Z_W'(r_z);
    assign acc_abs = r_acc[pfs_pkg::ACC_W-1] ? pfs_pkg::ACC_W'(-r_acc)
                                             : pfs_pkg::ACC_W'(r_acc);
    assign acc_mag = acc_abs[pfs_pkg::MAG_W-1:0];

    pfs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (z_mag),
        .i_b     (acc_mag),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    pfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pfs_pkg::S_MUL;
                end
            end
            pfs_pkg::S_MUL: begin
                n_state = pfs_pkg::S_MULW;
            end
            pfs_pkg::S_MULW: begin
                if (mul_done) begin
                    n_state = pfs_pkg::S_HDIV;
                end
            end
            pfs_pkg::S_HDIV: begin
                if (div_done) begin
                    n_state = last_term ? pfs_pkg::S_FDIV : pfs_pkg::S_MUL;
                end
            end
            pfs_pkg::S_FDIV: begin
                if (r_k < pfs_pkg::K_W'(2)) begin
                    n_state = pfs_pkg::S_FIN;
                end else begin
                    n_state = pfs_pkg::S_FWAIT;
                end
            end
            pfs_pkg::S_FWAIT: begin
                if (div_done) begin
                    n_state = pfs_pkg::S_FDIV;
                end
            end
            pfs_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = pfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and unit control
    always_comb begin
        logic                              nz;
        logic [pfs_pkg::UPD_W-1:0]         q_mag;
        logic signed [pfs_pkg::UPD_W-1:0]  upd;
        logic signed [pfs_pkg::ACC_W-1:0]  shifted;

        n_z          = r_z;
        n_ord        = r_ord;
        n_k          = r_k;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_sat        = r_sat;
        n_lo_ge      = r_lo_ge;
        n_phi        = r_phi;
        n_sat_out    = r_sat_out;
        // a waiting result leaves when the receiver takes it
        n_out_valid  = r_out_valid && i_out_stall;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = pfs_pkg::DIV_W'(prod[pfs_pkg::PROD_W-1:pfs_pkg::Z_FRAC]);
        nz           = 1'b0;
        q_mag        = '0;
        upd          = '0;
        shifted      = r_acc >>> (pfs_pkg::ACC_FRAC - pfs_pkg::OUT_FRAC);

        case (r_state)
            pfs_pkg::S_IDLE: begin
                if (in_accept) begin
                    // orders above the table limit saturate
                    if (int'(i_order) > pfs_pkg::MAX_ORDER) begin
                        n_ord = pfs_pkg::K_W'(pfs_pkg::MAX_ORDER);
                        n_k   = pfs_pkg::K_W'(pfs_pkg::MAX_ORDER + pfs_pkg::SERIES_TERMS);
                    end else begin
                        n_ord = pfs_pkg::K_W'(i_order);
                        n_k   = pfs_pkg::K_W'(int'(i_order) + pfs_pkg::SERIES_TERMS);
                    end
                    n_z   = i_z;
                    n_acc = pfs_pkg::ACC_ONE;
                    n_sat = 1'b0;
                end
            end
            pfs_pkg::S_MUL: begin
                mul_start = 1'b1;
                n_neg     = r_z[pfs_pkg::Z_W-1] ^ r_acc[pfs_pkg::ACC_W-1];
            end
            pfs_pkg::S_MULW: begin
                // |z*r| / 2^30 goes to the divider; the low bits only tell
                // whether the truncated quotient has a nonzero fraction part
                if (mul_done) begin
                    div_start = 1'b1;
                    n_lo_ge   = (prod[pfs_pkg::Z_FRAC-1:0] >= pfs_pkg::Z_FRAC'(r_k));
                end
            end
            pfs_pkg::S_HDIV: begin
                if (div_done) begin
                    // floor of a negative truncated quotient rounds one further
                    nz    = (div_rem != '0) || r_lo_ge;
                    q_mag = pfs_pkg::UPD_W'(div_quot) + pfs_pkg::UPD_W'(r_neg && nz);
                    upd   = r_neg ? -signed'(q_mag) : signed'(q_mag);
                    upd   = upd + pfs_pkg::UPD_W'(pfs_pkg::ACC_ONE);
                    if (upd > pfs_pkg::UPD_W'(pfs_pkg::ACC_LIMIT)) begin
                        n_acc = pfs_pkg::ACC_LIMIT;
                        n_sat = 1'b1;
                    end else if (upd < -pfs_pkg::UPD_W'(pfs_pkg::ACC_LIMIT)) begin
                        n_acc = -pfs_pkg::ACC_LIMIT;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = pfs_pkg::ACC_W'(upd);
                    end
                    n_k = last_term ? r_ord : pfs_pkg::K_W'(r_k - 1'b1);
                end
            end
            pfs_pkg::S_FDIV: begin
                // divide by n! one factor at a time, truncating toward zero
                if (r_k >= pfs_pkg::K_W'(2)) begin
                    div_start    = 1'b1;
                    div_dividend = pfs_pkg::DIV_W'(acc_mag);
                    n_neg        = r_acc[pfs_pkg::ACC_W-1];
                end
            end
            pfs_pkg::S_FWAIT: begin
                if (div_done) begin
                    n_acc = r_neg ? -signed'(pfs_pkg::ACC_W'(div_quot))
                                  : signed'(pfs_pkg::ACC_W'(div_quot));
                    n_k   = pfs_pkg::K_W'(r_k - 1'b1);
                end
            end
            pfs_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_sat_out   = r_sat;
                    if (shifted > pfs_pkg::OUT_MAX) begin
                        n_phi     = pfs_pkg::OUT_W'(pfs_pkg::OUT_MAX);
                        n_sat_out = 1'b1;
                    end else if (shifted < pfs_pkg::OUT_MIN) begin
                        n_phi     = pfs_pkg::OUT_W'(pfs_pkg::OUT_MIN);
                        n_sat_out = 1'b1;
                    end else begin
                        n_phi = pfs_pkg::OUT_W'(shifted);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_z       <= n_z;
        r_ord     <= n_ord;
        r_k       <= n_k;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_sat     <= n_sat;
        r_lo_ge   <= n_lo_ge;
        r_phi     <= n_phi;
        r_sat_out <= n_sat_out;
    end

    assign o_in_stall  = (r_state != pfs_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_phi_value = r_phi;
    assign o_saturated = r_sat_out;

endmodule

/* rtl/core/pfs_mul.sv */
// registered unsigned multiplier for the magnitude of z times the accumulator
module pfs_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfs_pkg::Z_W-1:0]       i_a,
    input  logic [pfs_pkg::MAG_W-1:0]     i_b,
    output logic                          o_done,
    output logic [pfs_pkg::PROD_W-1:0]    o_prod
);

    logic                        r_done;
    logic [pfs_pkg::PROD_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= pfs_pkg::PROD_W'(i_a) * pfs_pkg::PROD_W'(i_b);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* rtl/core/pfs_div.sv */
// digit-serial restoring divider by a small unsigned integer
module pfs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfs_pkg::DIV_W-1:0]     i_dividend,
    input  logic [pfs_pkg::K_W-1:0]       i_divisor,
    output logic                          o_done,
    output logic [pfs_pkg::DIV_W-1:0]     o_quot,
    output logic [pfs_pkg::K_W-1:0]       o_rem
);

    logic [pfs_pkg::DIV_W-1:0]   r_work;
    logic [pfs_pkg::DIV_W-1:0]   n_work;
    logic [pfs_pkg::K_W-1:0]     r_rem;
    logic [pfs_pkg::K_W-1:0]     n_rem;
    logic [pfs_pkg::K_W-1:0]     r_dvsr;
    logic [pfs_pkg::DCNT_W-1:0]  r_cnt;
    logic                        r_done;

    // one digit of DIG_W quotient bits per cycle, msb first
    always_comb begin
        logic [pfs_pkg::K_W:0] trial;
        n_rem  = r_rem;
        n_work = r_work;
        trial  = '0;
        for (int j = 0; j < pfs_pkg::DIG_W; j++) begin
            trial  = {n_rem, n_work[pfs_pkg::DIV_W-1]};
            n_work = {n_work[pfs_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                n_rem     = pfs_pkg::K_W'(trial - {1'b0, r_dvsr});
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial[pfs_pkg::K_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= pfs_pkg::DCNT_W'(pfs_pkg::DIV_DIGITS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == pfs_pkg::DCNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;
    assign o_rem  = r_rem;

endmodule
